[hdl/kfseg_pkg.sv]
`default_nettype none
package kfseg_pkg;

    localparam int MAX_FRAMES_DEF = 32;
    localparam int TIME_BITS_DEF  = 16;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_GOTO  = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic EV_ENTER = 1'b0;
    localparam logic EV_APPLY = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot;
        logic [15:0] key_time;
        logic        enter_when_passed;
        logic [15:0] target_frame;
    } t_in_item;

    typedef struct packed {
        logic        event_res;
        logic [4:0]  key_slot;
        logic [4:0]  next_slot;
        logic [15:0] enter_time;
        logic [15:0] progress;
        logic        last;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_STEP_CHK,
        S_RD0,
        S_RDL,
        S_DECIDE,
        S_BS_MID,
        S_BS_A,
        S_BS_B,
        S_BS_END,
        S_BS_E1,
        S_BS_E2,
        S_W_NEXT,
        S_W_A,
        S_W_B,
        S_W_END,
        S_ENTER,
        S_APPLY,
        S_DIV,
        S_AOUT
    } t_state;

endpackage
`default_nettype wire

[hdl/keyframe_segment_locator.sv]
`default_nettype none
// Keyframe segment locator. Keyframe times and their enter-when-passed flags are
// loaded with write transactions (kind 0) into a table with one write port;
// frame_count, set by any APB write (paddr is not decoded), selects how many
// entries are in use. A goto transaction (kind 1) binary-searches the table for the
// segment holding the target time; a step transaction (kind 2) searches only when
// the target leaves the current segment, walking forward one entry at a time and
// emitting an enter result for each flagged keyframe it passes. While frame_count
// is nonzero, every goto/step ends with an apply result carrying the elapsed
// fraction of the segment as unsigned Q0.16; only that result has last set.
// All table reads go through one registered read port; a goto makes about
// log2(frame_count) binary-search probes. The apply fraction comes from a restoring
// divider with a 16-bit quotient, one quotient bit per cycle, skipped when the span
// is zero, the target lies before the segment start or the fraction saturates.
// Enter and apply results wait while the result register is still held by the sink.
// The input side stalls while a transaction is being worked on; the result register
// lets the next transaction be taken while the last result waits.
module keyframe_segment_locator #(
    parameter int MAX_FRAMES = kfseg_pkg::MAX_FRAMES_DEF,
    parameter int TIME_BITS  = kfseg_pkg::TIME_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  kfseg_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output kfseg_pkg::t_out_item  o_out_data,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [1:0]            paddr,
    input  wire  [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int TB = TIME_BITS;
    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);
    localparam int CW = NW + 1;
    localparam int SW = IW + 2;

    // table storage
    logic [TB-1:0] r_mem_time [MAX_FRAMES];
    logic          r_mem_flag [MAX_FRAMES];
    logic [TB-1:0] r_rd_time;
    logic          r_rd_flag;
    logic [IW-1:0] rd_addr;

    // control and segment state
    kfseg_pkg::t_state r_state, n_state;
    logic [5:0]        r_fc;
    logic [1:0]        r_kind, n_kind;
    logic [TB-1:0]     r_t, n_t;
    logic [TB-1:0]     r_tc, n_tc;
    logic [TB-1:0]     r_t0, n_t0;
    logic [TB-1:0]     r_tm, n_tm;
    logic [TB-1:0]     r_start, n_start;
    logic [TB-1:0]     r_span, n_span;
    logic [IW-1:0]     r_cur, n_cur;
    logic              r_cur_valid, n_cur_valid;
    logic [IW-1:0]     r_from, n_from;
    logic [IW-1:0]     r_to, n_to;
    logic [IW-1:0]     r_mid, n_mid;
    logic [IW-1:0]     r_target, n_target;
    logic signed [SW-1:0] r_lo, n_lo;
    logic signed [SW-1:0] r_hi, n_hi;
    logic [NW-1:0]     r_i, n_i;
    logic              r_wflag, n_wflag;
    logic [TB-1:0]     r_wtime, n_wtime;
    logic [IW-1:0]     r_e_key, n_e_key;
    logic [IW-1:0]     r_e_next, n_e_next;
    logic [TB-1:0]     r_e_time, n_e_time;
    logic              r_e_walk, n_e_walk;
    logic [TB-1:0]     r_rem, n_rem;
    logic [15:0]       r_q, n_q;
    logic [3:0]        r_dcnt, n_dcnt;
    logic              r_out_valid;
    kfseg_pkg::t_out_item r_out;
    kfseg_pkg::t_out_item n_out;
    logic              out_load;

    logic [NW-1:0] w_n;
    logic [IW-1:0] w_n1;
    logic          out_free;
    logic          in_acc;
    logic [TB:0]   seg_end;
    logic [TB:0]   rem2;
    logic [IW-1:0] w_next_f;
    logic [TB-1:0] w_diff;

    assign w_n  = (7'(r_fc) > 7'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(r_fc);
    assign w_n1 = IW'(w_n - NW'(1));
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_acc   = i_in_valid && !o_in_stall;
    assign seg_end  = {1'b0, r_start} + {1'b0, r_span};
    assign rem2     = {r_rem, 1'b0};
    assign w_diff   = r_t - r_start;
    assign w_next_f = (CW'(r_to) + CW'(1) >= CW'(w_n)) ? '0 : IW'(r_to + IW'(1));

    assign o_in_stall  = (r_state != kfseg_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = 32'(r_fc);

    // single write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.kind == kfseg_pkg::KIND_WRITE
                && 6'(i_in_data.slot) < 6'(MAX_FRAMES)) begin
            r_mem_time[IW'(i_in_data.slot)] <= TB'(i_in_data.key_time);
            r_mem_flag[IW'(i_in_data.slot)] <= i_in_data.enter_when_passed;
        end
        r_rd_time <= r_mem_time[rd_addr];
        r_rd_flag <= r_mem_flag[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kfseg_pkg::S_IDLE;
            r_fc        <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_start     <= '0;
            r_span      <= '0;
            r_from      <= '0;
            r_to        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (psel && penable && pwrite) begin
                r_fc <= pwdata[5:0];
            end
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_start     <= n_start;
            r_span      <= n_span;
            r_from      <= n_from;
            r_to        <= n_to;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_t      <= n_t;
        r_tc     <= n_tc;
        r_t0     <= n_t0;
        r_tm     <= n_tm;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_i      <= n_i;
        r_wflag  <= n_wflag;
        r_wtime  <= n_wtime;
        r_e_key  <= n_e_key;
        r_e_next <= n_e_next;
        r_e_time <= n_e_time;
        r_e_walk <= n_e_walk;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_dcnt   <= n_dcnt;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_state = r_state;   n_kind = r_kind;     n_t = r_t;         n_tc = r_tc;
        n_t0 = r_t0;         n_tm = r_tm;         n_start = r_start; n_span = r_span;
        n_cur = r_cur;       n_cur_valid = r_cur_valid;
        n_from = r_from;     n_to = r_to;         n_mid = r_mid;     n_target = r_target;
        n_lo = r_lo;         n_hi = r_hi;         n_i = r_i;
        n_wflag = r_wflag;   n_wtime = r_wtime;
        n_e_key = r_e_key;   n_e_next = r_e_next; n_e_time = r_e_time; n_e_walk = r_e_walk;
        n_rem = r_rem;       n_q = r_q;           n_dcnt = r_dcnt;
        rd_addr  = '0;
        out_load = 1'b0;
        n_out    = '0;

        unique case (r_state)
            kfseg_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_kind = i_in_data.kind;
                    n_t    = TB'(i_in_data.target_frame);
                    if (w_n != '0 && i_in_data.kind == kfseg_pkg::KIND_GOTO) begin
                        n_state = kfseg_pkg::S_RD0;
                    end else if (w_n != '0 && i_in_data.kind == kfseg_pkg::KIND_STEP) begin
                        n_state = kfseg_pkg::S_STEP_CHK;
                    end
                end
            end
            kfseg_pkg::S_STEP_CHK: begin
                // search only when the target leaves the current segment
                if (r_t < r_start || {1'b0, r_t} >= seg_end) begin
                    n_state = kfseg_pkg::S_RD0;
                end else begin
                    n_state = kfseg_pkg::S_APPLY;
                end
            end
            kfseg_pkg::S_RD0: begin
                rd_addr = '0;
                n_state = kfseg_pkg::S_RDL;
            end
            kfseg_pkg::S_RDL: begin
                n_t0    = r_rd_time;
                rd_addr = w_n1;
                n_state = kfseg_pkg::S_DECIDE;
            end
            kfseg_pkg::S_DECIDE: begin
                // r_rd_time/r_rd_flag hold the last active entry here
                n_e_walk = 1'b0;
                n_e_time = r_t;
                if (r_kind == kfseg_pkg::KIND_GOTO) begin
                    if (r_t < r_t0) begin
                        n_from = '0; n_to = '0;
                        n_start = '0; n_span = r_t0;
                        if (r_start >= r_t0 || !r_cur_valid || r_cur != '0) begin
                            n_cur = '0; n_cur_valid = 1'b1;
                            n_e_key = '0; n_e_next = '0;
                            n_state = kfseg_pkg::S_ENTER;
                        end else begin
                            n_state = kfseg_pkg::S_APPLY;
                        end
                    end else if (r_t >= r_rd_time) begin
                        n_from = w_n1; n_to = '0;
                        n_start = r_rd_time; n_span = '0;
                        if (r_rd_flag || !r_cur_valid || r_cur != w_n1) begin
                            n_cur = w_n1; n_cur_valid = 1'b1;
                            n_e_key = w_n1; n_e_next = w_n1;
                            n_state = kfseg_pkg::S_ENTER;
                        end else begin
                            n_state = kfseg_pkg::S_APPLY;
                        end
                    end else begin
                        n_lo = '0;
                        n_hi = SW'(w_n) - SW'(1);
                        n_target = '0;
                        n_state = kfseg_pkg::S_BS_MID;
                    end
                end else begin
                    if (r_t < r_t0) begin
                        n_start = '0; n_span = r_t0;
                        n_cur = '0; n_cur_valid = 1'b1;
                        n_e_key = '0; n_e_next = '0;
                        n_state = kfseg_pkg::S_ENTER;
                    end else if (r_t >= r_rd_time && r_start >= r_rd_time) begin
                        n_state = kfseg_pkg::S_APPLY;
                    end else begin
                        // clamp past the last keyframe
                        n_tc = (r_t >= r_rd_time) ? r_rd_time : r_t;
                        if (CW'(r_to) >= CW'(w_n)) begin
                            n_to = '0;
                        end
                        n_i = '0;
                        n_state = kfseg_pkg::S_W_NEXT;
                    end
                end
            end
            kfseg_pkg::S_BS_MID: begin
                if (r_lo > r_hi) begin
                    n_target = '0;
                    n_state = kfseg_pkg::S_BS_END;
                end else begin
                    n_mid = IW'((r_lo + r_hi) >>> 1);
                    rd_addr = IW'((r_lo + r_hi) >>> 1);
                    n_state = kfseg_pkg::S_BS_A;
                end
            end
            kfseg_pkg::S_BS_A: begin
                n_tm = r_rd_time;
                rd_addr = IW'(r_mid + IW'(1));
                n_state = kfseg_pkg::S_BS_B;
            end
            kfseg_pkg::S_BS_B: begin
                if (r_t >= r_tm && CW'(r_mid) + CW'(1) < CW'(w_n) && r_t < r_rd_time) begin
                    n_target = r_mid;
                    n_state = kfseg_pkg::S_BS_END;
                end else begin
                    if (r_tm > r_t) begin
                        n_hi = SW'(r_mid) - SW'(1);
                    end else begin
                        n_lo = SW'(r_mid) + SW'(1);
                    end
                    n_state = kfseg_pkg::S_BS_MID;
                end
            end
            kfseg_pkg::S_BS_END: begin
                rd_addr = r_target;
                n_state = kfseg_pkg::S_BS_E1;
            end
            kfseg_pkg::S_BS_E1: begin
                n_tm = r_rd_time;
                rd_addr = IW'(r_target + IW'(1));
                n_state = kfseg_pkg::S_BS_E2;
            end
            kfseg_pkg::S_BS_E2: begin
                n_from  = r_target;
                n_to    = IW'(r_target + IW'(1));
                n_start = r_tm;
                n_span  = r_rd_time - r_tm;
                if ((r_target == '0 && r_start < r_tm) || !r_cur_valid
                        || r_cur != r_target) begin
                    n_cur = r_target; n_cur_valid = 1'b1;
                    n_e_key = r_target; n_e_next = IW'(r_target + IW'(1));
                    n_state = kfseg_pkg::S_ENTER;
                end else begin
                    n_state = kfseg_pkg::S_APPLY;
                end
            end
            kfseg_pkg::S_W_NEXT: begin
                if (CW'(r_i) < CW'(w_n)) begin
                    rd_addr = r_to;
                    n_state = kfseg_pkg::S_W_A;
                end else begin
                    n_state = kfseg_pkg::S_W_END;
                end
            end
            kfseg_pkg::S_W_A: begin
                // take entry f = r_to, advance to_slot, fetch the following entry
                n_i     = NW'(r_i + NW'(1));
                n_from  = r_to;
                n_start = r_rd_time;
                n_wtime = r_rd_time;
                n_wflag = r_rd_flag;
                n_to    = w_next_f;
                rd_addr = w_next_f;
                n_state = kfseg_pkg::S_W_B;
            end
            kfseg_pkg::S_W_B: begin
                n_tm = r_rd_time;
                if (r_tc == r_wtime || (r_tc > r_wtime && r_tc < r_rd_time)) begin
                    n_state = kfseg_pkg::S_W_END;
                end else if (r_wflag) begin
                    n_e_key  = r_from;
                    n_e_next = r_to;
                    n_e_time = r_wtime;
                    n_e_walk = 1'b1;
                    n_state  = kfseg_pkg::S_ENTER;
                end else begin
                    n_state = kfseg_pkg::S_W_NEXT;
                end
            end
            kfseg_pkg::S_W_END: begin
                n_span = (r_from == w_n1) ? '0 : r_tm - r_wtime;
                n_cur = r_from; n_cur_valid = 1'b1;
                n_e_key  = r_from;
                n_e_next = (r_from == w_n1) ? r_from : r_to;
                n_e_time = r_tc;
                n_e_walk = 1'b0;
                n_state  = kfseg_pkg::S_ENTER;
            end
            kfseg_pkg::S_ENTER: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out.event_res  = kfseg_pkg::EV_ENTER;
                    n_out.key_slot   = 5'(r_e_key);
                    n_out.next_slot  = 5'(r_e_next);
                    n_out.enter_time = 16'(r_e_time);
                    n_state = r_e_walk ? kfseg_pkg::S_W_NEXT : kfseg_pkg::S_APPLY;
                end
            end
            kfseg_pkg::S_APPLY: begin
                n_q = '0;
                n_rem = w_diff;
                n_dcnt = '0;
                if (!r_cur_valid) begin
                    n_state = kfseg_pkg::S_IDLE;
                end else if (r_span != '0 && r_t >= r_start) begin
                    if (w_diff >= r_span) begin
                        n_q = '1;
                        n_state = kfseg_pkg::S_AOUT;
                    end else begin
                        n_state = kfseg_pkg::S_DIV;
                    end
                end else begin
                    n_state = kfseg_pkg::S_AOUT;
                end
            end
            kfseg_pkg::S_DIV: begin
                // restoring divide, one quotient bit per cycle
                if (rem2 >= {1'b0, r_span}) begin
                    n_rem = TB'(rem2 - {1'b0, r_span});
                    n_q = {r_q[14:0], 1'b1};
                end else begin
                    n_rem = TB'(rem2);
                    n_q = {r_q[14:0], 1'b0};
                end
                n_dcnt = r_dcnt + 4'd1;
                if (r_dcnt == 4'd15) begin
                    n_state = kfseg_pkg::S_AOUT;
                end
            end
            kfseg_pkg::S_AOUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_out.event_res = kfseg_pkg::EV_APPLY;
                    n_out.key_slot  = 5'(r_cur);
                    n_out.progress  = r_q;
                    n_out.last      = 1'b1;
                    n_state = kfseg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kfseg_pkg::S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_last_is_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last == (o_out_data.event_res == kfseg_pkg::EV_APPLY)))
        else $error("last flag not tied to apply result");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kfseg_pkg::S_DIV |-> r_rem < r_span)
        else $error("divider remainder out of range");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kfseg_pkg::S_W_A |-> CW'(r_i) < CW'(w_n))
        else $error("forward walk exceeded frame count");
    a_apply_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == kfseg_pkg::S_AOUT |-> r_cur_valid)
        else $error("apply without current keyframe");
`endif

endmodule
`default_nettype wire
